@@ design/pgsa_pkg.sv @@
// Package for the proximity-gated sample averager.
// Shared types, command codes and fixed-point constants; no dependencies.
`default_nettype none

package pgsa_pkg;

	localparam int unsigned SAMPLE_BITS_DEF = 8;

	// cm per 1 us tick in Q16 (0.01715 cm/us, rounded)
	localparam logic [10:0] CM_PER_TICK_Q16 = 11'd1124;

	localparam logic [7:0] CMD_MANUAL   = 8'h6D; // 'm'
	localparam logic [7:0] CMD_DISTANCE = 8'h64; // 'd'

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_SAMPLE  = 2'd1,
		KIND_COMMAND = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CFG_TRIGGER_TICKS = 3'd0,
		CFG_ECHO_TIMEOUT  = 3'd1,
		CFG_GAP_TICKS     = 3'd2,
		CFG_NEAR_THRESH   = 3'd3,
		CFG_NO_ECHO_DIST  = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_IDLE     = 3'b001,
		OP_MANUAL   = 3'b010,
		OP_DISTANCE = 3'b100
	} opmode_t;

	typedef enum logic [3:0] {
		PH_TRIGGER = 4'b0001,
		PH_WAIT    = 4'b0010,
		PH_MEASURE = 4'b0100,
		PH_GAP     = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0]  trigger_ticks;
		logic [15:0] echo_timeout_ticks;
		logic [15:0] gap_ticks;
		logic [7:0]  near_threshold_cm;
		logic [7:0]  no_echo_distance_cm;
	} cfg_t;

	// ranger status: current gating state plus post-word indicator values
	typedef struct packed {
		logic       manual;
		logic       near_now;
		logic       trigger;
		logic       led_next;
		logic       near_next;
		logic [7:0] dist_next;
	} rng_stat_t;

endpackage

`default_nettype wire

@@ design/pgsa_ranger.sv @@
// Ranging sequencer: operating mode, trigger/echo/gap phases, distance and near flag.
// Depends on pgsa_pkg.
`default_nettype none

module pgsa_ranger
	import pgsa_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [1:0] mode,
	input  wire logic       echo_level,
	input  wire logic [7:0] command_byte,
	input  wire cfg_t       cfg,
	output rng_stat_t       stat
);

	opmode_t     opmode_q, opmode_d;
	phase_t      phase_q, phase_d;
	logic [15:0] count_q, count_d, count_up;
	logic        near_q, near_d;
	logic        led_q, led_d;
	logic [7:0]  dist_q, dist_d;
	logic        fin;
	logic [7:0]  fin_dist;
	logic [7:0]  trig_len;
	logic [26:0] meas_prod;
	logic [7:0]  meas_dist;
	logic        fin_near;

	assign count_up  = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;
	assign trig_len  = (cfg.trigger_ticks == 8'd0) ? 8'd1 : cfg.trigger_ticks;
	assign meas_prod = {11'd0, count_up} * {16'd0, CM_PER_TICK_Q16};
	assign meas_dist = (|meas_prod[26:24]) ? 8'hFF : meas_prod[23:16];
	assign fin_near  = fin_dist < cfg.near_threshold_cm;

	always_comb begin
		opmode_d = opmode_q;
		phase_d  = phase_q;
		count_d  = count_q;
		near_d   = near_q;
		led_d    = led_q;
		dist_d   = dist_q;
		fin      = 1'b0;
		fin_dist = cfg.no_echo_distance_cm;
		case (mode)
			KIND_TICK: begin
				if (opmode_q == OP_DISTANCE) begin
					unique case (phase_q)
						PH_TRIGGER: begin
							count_d = count_up;
							if (count_up >= {8'd0, trig_len})
								phase_d = PH_WAIT;
						end
						PH_WAIT: begin
							if (echo_level) begin
								phase_d = PH_MEASURE;
								count_d = 16'd0;
							end else begin
								count_d = count_up;
								fin     = count_up > cfg.echo_timeout_ticks;
							end
						end
						PH_MEASURE: begin
							count_d = count_up;
							if (!echo_level) begin
								fin      = 1'b1;
								fin_dist = meas_dist;
							end else begin
								fin = count_up > cfg.echo_timeout_ticks;
							end
						end
						PH_GAP: begin
							count_d = count_up;
							if (count_up >= cfg.gap_ticks) begin
								phase_d = PH_TRIGGER;
								count_d = 16'd0;
							end
						end
						default: ;
					endcase
				end
			end
			KIND_COMMAND: begin
				if (command_byte == CMD_MANUAL || command_byte == CMD_DISTANCE) begin
					opmode_d = (command_byte == CMD_MANUAL) ? OP_MANUAL : OP_DISTANCE;
					led_d    = (command_byte == CMD_MANUAL);
					near_d   = 1'b0;
					phase_d  = PH_TRIGGER;
					count_d  = 16'd0;
				end
			end
			default: ;
		endcase
		// end of a ranging cycle
		if (fin) begin
			dist_d  = fin_dist;
			near_d  = fin_near;
			led_d   = fin_near;
			count_d = 16'd0;
			phase_d = (cfg.gap_ticks == 16'd0) ? PH_TRIGGER : PH_GAP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opmode_q <= OP_IDLE;
			phase_q  <= PH_TRIGGER;
			count_q  <= 16'd0;
			near_q   <= 1'b0;
			led_q    <= 1'b0;
			dist_q   <= 8'd0;
		end else if (accept) begin
			opmode_q <= opmode_d;
			phase_q  <= phase_d;
			count_q  <= count_d;
			near_q   <= near_d;
			led_q    <= led_d;
			dist_q   <= dist_d;
		end
	end

	assign stat.manual    = (opmode_q == OP_MANUAL);
	assign stat.near_now  = near_q;
	assign stat.trigger   = (opmode_q == OP_DISTANCE) && (phase_q == PH_TRIGGER);
	assign stat.led_next  = led_d;
	assign stat.near_next = near_d;
	assign stat.dist_next = dist_d;

endmodule

`default_nettype wire

@@ design/pgsa_avg.sv @@
// Sample gate and two-point averager with first-sample pass-through.
// Depends on pgsa_pkg.
`default_nettype none

module pgsa_avg
	import pgsa_pkg::*;
#(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire logic [1:0]             mode,
	input  wire logic [SAMPLE_BITS-1:0] sample_in,
	input  wire logic                   gate_open,
	output logic                        pass,
	output logic [SAMPLE_BITS-1:0]      avg
);

	logic [SAMPLE_BITS-1:0] prev_q;
	logic                   first_q;
	logic [SAMPLE_BITS:0]   sum;

	assign pass = (mode == KIND_SAMPLE) && gate_open;
	assign sum  = {1'b0, sample_in} + {1'b0, prev_q};

	always_comb begin
		if (!pass)
			avg = '0;
		else if (first_q)
			avg = sample_in;
		else
			avg = sum[SAMPLE_BITS:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			first_q <= 1'b1;
		end else if (accept && pass) begin
			prev_q  <= sample_in;
			first_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ design/proximity_gated_sample_averager_top.sv @@
// Top level of the proximity-gated sample averager: config registers, ranger,
// averager and the result register. Depends on pgsa_pkg, pgsa_ranger, pgsa_avg.
`default_nettype none

// Takes one word (tick, sample or command) per clock and returns one result word
// per input word, in the cycle after acceptance, from a single result register.
// in_stall is high only while that register holds a word the sink is stalling,
// so with out_stall low the block sustains one word per cycle. trigger_level
// shows the trigger drive in effect while the word ran; led_on, object_near and
// distance_cm show the state after it. The config port is always ready and
// should be written only while the block is idle.
module proximity_gated_sample_averager_top
	import pgsa_pkg::*;
#(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [15:0]            cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             mode,
	input  wire logic                   echo_level,
	input  wire logic [SAMPLE_BITS-1:0] sample_in,
	input  wire logic [7:0]             command_byte,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        sample_valid,
	output logic [SAMPLE_BITS-1:0]      sample_out,
	output logic                        trigger_level,
	output logic                        led_on,
	output logic                        object_near,
	output logic [7:0]                  distance_cm
);

	cfg_t                   cfg_q;
	rng_stat_t              stat;
	logic                   accept;
	logic                   pass;
	logic [SAMPLE_BITS-1:0] avg;
	logic                   out_valid_q;
	logic                   sample_valid_q;
	logic [SAMPLE_BITS-1:0] sample_out_q;
	logic                   trigger_q;
	logic                   led_q;
	logic                   near_q;
	logic [7:0]             dist_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks       <= 8'd10;
			cfg_q.echo_timeout_ticks  <= 16'd1000;
			cfg_q.gap_ticks           <= 16'd60000;
			cfg_q.near_threshold_cm   <= 8'd10;
			cfg_q.no_echo_distance_cm <= 8'd100;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TRIGGER_TICKS: cfg_q.trigger_ticks       <= cfg_data[7:0];
				CFG_ECHO_TIMEOUT:  cfg_q.echo_timeout_ticks  <= cfg_data;
				CFG_GAP_TICKS:     cfg_q.gap_ticks           <= cfg_data;
				CFG_NEAR_THRESH:   cfg_q.near_threshold_cm   <= cfg_data[7:0];
				CFG_NO_ECHO_DIST:  cfg_q.no_echo_distance_cm <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	pgsa_ranger u_ranger (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.mode         (mode),
		.echo_level   (echo_level),
		.command_byte (command_byte),
		.cfg          (cfg_q),
		.stat         (stat)
	);

	pgsa_avg #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_avg (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.mode      (mode),
		.sample_in (sample_in),
		.gate_open (stat.manual || stat.near_now),
		.pass      (pass),
		.avg       (avg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_valid_q <= pass;
			sample_out_q   <= avg;
			trigger_q      <= stat.trigger;
			led_q          <= stat.led_next;
			near_q         <= stat.near_next;
			dist_q         <= stat.dist_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign sample_valid  = sample_valid_q;
	assign sample_out    = sample_out_q;
	assign trigger_level = trigger_q;
	assign led_on        = led_q;
	assign object_near   = near_q;
	assign distance_cm   = dist_q;

endmodule

`default_nettype wire

@@ design/pgsa_checker.sv @@
// Port-level checks for proximity_gated_sample_averager_top, bound to the top.
// Depends on pgsa_pkg and the top level.
`default_nettype none

module pgsa_checker
	import pgsa_pkg::*;
#(
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic                   sample_valid,
	input wire logic [SAMPLE_BITS-1:0] sample_out,
	input wire logic                   led_on,
	input wire logic                   object_near
);

	// accepted word always produces a result on the next edge
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted word produced no result");

	// input may only stall behind a held result
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

	a_blocked_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !sample_valid) |-> (sample_out == '0))
		else $error("blocked sample word carries nonzero data");

	// near always lights the indicator
	a_near_led: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && object_near) |-> led_on)
		else $error("object near without indicator");

endmodule

bind proximity_gated_sample_averager_top pgsa_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_pgsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sample_valid (sample_valid),
	.sample_out   (sample_out),
	.led_on       (led_on),
	.object_near  (object_near)
);

`default_nettype wire
